### rtl/c_like_token_lexer_assert.svh
// assertion macros for the token lexer
// included by the top level, no other dependencies
`ifndef C_LIKE_TOKEN_LEXER_ASSERT_SVH
`define C_LIKE_TOKEN_LEXER_ASSERT_SVH

// same-cycle implication
`define CTLEX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("token lexer assertion failed");

// next-cycle implication
`define CTLEX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("token lexer assertion failed");

`endif

### rtl/ctlex_pkg.sv
// token kinds, scan modes, keyword table and byte classes for the token lexer
// no dependencies
package ctlex_pkg;

   localparam int LINE_BITS_DEF   = 16;
   localparam int COLUMN_BITS_DEF = 12;
   localparam int LENGTH_BITS_DEF = 12;
   localparam int KEYWORD_MAX_DEF = 6;

   localparam int KIND_BITS  = 6;
   localparam int KW_COUNT   = 11;
   localparam int KW_CHARS   = 6;
   localparam int KW_BITS    = 8 * KW_CHARS;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;

   typedef enum logic [KIND_BITS-1:0] {
      K_PLUS, K_MINUS, K_MULTIPLY, K_DIVIDE, K_MODULO, K_ASSIGN, K_EQUAL,
      K_NOT_EQUAL, K_LESS_THAN, K_GREATER_THAN, K_LESS_EQUAL, K_GREATER_EQUAL,
      K_IF, K_ELSE, K_WHILE, K_FOR, K_RETURN, K_INT, K_FLOAT, K_DOUBLE,
      K_CHAR, K_STRING, K_VOID, K_IDENTIFIER, K_INTEGER_LITERAL,
      K_FLOAT_LITERAL, K_STRING_LITERAL, K_SEMICOLON, K_COMMA, K_LEFT_PAREN,
      K_RIGHT_PAREN, K_LEFT_BRACE, K_RIGHT_BRACE, K_LOGICAL_AND, K_LOGICAL_OR,
      K_LOGICAL_NOT, K_END_OF_FILE, K_UNKNOWN
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_OP, MODE_INT, MODE_FRAC, MODE_IDENT, MODE_STR
   } mode_type;

   typedef enum logic [1:0] {
      PEND_ASSIGN, PEND_LESS, PEND_GREATER, PEND_NOT
   } pend_type;

   function automatic logic is_digit(logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] b);
      return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
   endfunction

   function automatic logic is_space(logic [7:0] b);
      return (b == " ") || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   function automatic logic is_type_kind(kind_type k);
      return k inside {[K_INT:K_VOID]};
   endfunction

   // kind of a byte that is a token on its own
   function automatic kind_type char_kind(logic [7:0] b);
      case (b)
         "+":     return K_PLUS;
         "-":     return K_MINUS;
         "*":     return K_MULTIPLY;
         "/":     return K_DIVIDE;
         "%":     return K_MODULO;
         "(":     return K_LEFT_PAREN;
         ")":     return K_RIGHT_PAREN;
         "{":     return K_LEFT_BRACE;
         "}":     return K_RIGHT_BRACE;
         ";":     return K_SEMICOLON;
         ",":     return K_COMMA;
         default: return K_UNKNOWN;
      endcase
   endfunction

   function automatic kind_type op_single(pend_type p);
      case (p)
         PEND_ASSIGN:  return K_ASSIGN;
         PEND_LESS:    return K_LESS_THAN;
         PEND_GREATER: return K_GREATER_THAN;
         default:      return K_LOGICAL_NOT;
      endcase
   endfunction

   function automatic kind_type op_double(pend_type p);
      case (p)
         PEND_ASSIGN:  return K_EQUAL;
         PEND_LESS:    return K_LESS_EQUAL;
         PEND_GREATER: return K_GREATER_EQUAL;
         default:      return K_NOT_EQUAL;
      endcase
   endfunction

   // keyword text, first letter in the lowest byte
   function automatic logic [KW_BITS-1:0] kw_text(logic [3:0] k);
      case (k)
         4'd0:    return 48'h6669;
         4'd1:    return 48'h65736c65;
         4'd2:    return 48'h656c696877;
         4'd3:    return 48'h726f66;
         4'd4:    return 48'h6e7275746572;
         4'd5:    return 48'h746e69;
         4'd6:    return 48'h74616f6c66;
         4'd7:    return 48'h656c62756f64;
         4'd8:    return 48'h72616863;
         4'd9:    return 48'h676e69727473;
         4'd10:   return 48'h64696f76;
         default: return '0;
      endcase
   endfunction

   function automatic logic [3:0] kw_len(logic [3:0] k);
      case (k)
         4'd0:    return 4'd2;
         4'd1:    return 4'd4;
         4'd2:    return 4'd5;
         4'd3:    return 4'd3;
         4'd4:    return 4'd6;
         4'd5:    return 4'd3;
         4'd6:    return 4'd5;
         4'd7:    return 4'd6;
         4'd8:    return 4'd4;
         4'd9:    return 4'd6;
         4'd10:   return 4'd4;
         default: return 4'd15;
      endcase
   endfunction

endpackage

### rtl/c_like_token_lexer.sv
// c_like_token_lexer: scans source bytes and queues up to two tokens per transfer
// a token enters the registered token queue on the byte transfer that closes it
// throughput: one byte per cycle while the token queue holds at most one token; a byte
//   that yields two tokens can stall req_tready until the three-entry token queue drains
// reset: synchronous, active high; counters go to line 1 column 1, queue empties
// depends on ctlex_pkg and c_like_token_lexer_assert.svh
module c_like_token_lexer #(
   parameter int LINE_BITS   = ctlex_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = ctlex_pkg::COLUMN_BITS_DEF,
   parameter int LENGTH_BITS = ctlex_pkg::LENGTH_BITS_DEF,
   parameter int KEYWORD_MAX = ctlex_pkg::KEYWORD_MAX_DEF,
   localparam int DATA_BITS  = ((LINE_BITS + COLUMN_BITS + LENGTH_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // source_byte
   input  logic                 req_tlast,   // end_of_source
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_BITS-1:0] rsp_tdata,   // token_line, token_column, value_length
   output logic [6:0]           rsp_tuser,   // token_kind, declares_symbol
   output logic                 rsp_tlast    // final_token
);
   import ctlex_pkg::*;

   localparam int KB_BITS = 8 * KEYWORD_MAX;
   localparam int QDEPTH  = 3;

   typedef struct packed {
      kind_type               kind;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] column;
      logic [LENGTH_BITS-1:0] length;
      logic                   decl;
      logic                   last;
   } tok_type;

   mode_type               mode_ff, mode_in;
   pend_type               pend_ff, pend_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [KB_BITS-1:0]     kbuf_ff, kbuf_in;
   logic                   prev_ff, prev_in;
   logic [1:0]             cnt_ff, cnt_in;
   tok_type                q_ff [QDEPTH];
   tok_type                q_in [QDEPTH];

   logic [7:0]             b;
   logic                   take, eos, pop;
   logic                   op_pair, num_more, ident_more, in_str, scanning;
   logic                   do_flush, scan_hit, ident_char;
   logic [LINE_BITS-1:0]   line_inc;
   logic [COLUMN_BITS-1:0] col_inc;
   logic [LENGTH_BITS-1:0] len_inc, fl_len;
   kind_type               fl_kind, id_kind;
   tok_type                tok0, tok1;
   logic [1:0]             n_tok, base;

   function automatic tok_type make_tok(kind_type k, logic [LINE_BITS-1:0] ln,
                                        logic [COLUMN_BITS-1:0] c,
                                        logic [LENGTH_BITS-1:0] l, logic fin);
      tok_type t;
      t.kind   = k;
      t.line   = ln;
      t.column = c;
      t.length = l;
      t.decl   = 1'b0;
      t.last   = fin;
      return t;
   endfunction

   assign b          = req_tdata;
   assign eos        = req_tlast;
   assign req_tready = (cnt_ff <= 2'd1);
   assign take       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   assign line_inc = (&line_ff) ? line_ff : line_ff + LINE_BITS'(1);
   assign col_inc  = (&col_ff) ? col_ff : col_ff + COLUMN_BITS'(1);
   assign len_inc  = (&len_ff) ? len_ff : len_ff + LENGTH_BITS'(1);

   assign ident_char = is_alpha(b) || is_digit(b) || (b == "_");
   assign op_pair    = (mode_ff == MODE_OP) && (b == "=");
   assign num_more   = ((mode_ff == MODE_INT) || (mode_ff == MODE_FRAC)) &&
                       (is_digit(b) || ((b == ".") && (mode_ff == MODE_INT)));
   assign ident_more = (mode_ff == MODE_IDENT) && ident_char;
   assign in_str     = (mode_ff == MODE_STR);
   assign scanning   = !(op_pair || num_more || ident_more || in_str);
   assign do_flush   = (mode_ff != MODE_IDLE) && (eos || scanning);
   assign scan_hit   = !is_space(b) && !is_digit(b) && !is_alpha(b) &&
                       !(b inside {"=", "<", ">", "!", "\"", "_"});

   // keyword match of the pending identifier
   always_comb begin
      id_kind = K_IDENTIFIER;
      if (len_ff <= LENGTH_BITS'(KEYWORD_MAX)) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            if ((len_ff == LENGTH_BITS'(kw_len(4'(k)))) &&
                (kbuf_ff == KB_BITS'(kw_text(4'(k))))) begin
               id_kind = kind_type'(KIND_BITS'(K_IF) + KIND_BITS'(k));
            end
         end
      end
   end

   always_comb begin
      fl_len = len_ff;
      case (mode_ff)
         MODE_OP: begin
            fl_kind = op_single(pend_ff);
            fl_len  = LENGTH_BITS'(1);
         end
         MODE_INT:   fl_kind = K_INTEGER_LITERAL;
         MODE_FRAC:  fl_kind = K_FLOAT_LITERAL;
         MODE_IDENT: fl_kind = id_kind;
         MODE_STR:   fl_kind = K_STRING_LITERAL;
         default:    fl_kind = K_UNKNOWN;
      endcase
   end

   // next scanner state
   always_comb begin
      mode_in = mode_ff;
      pend_in = pend_ff;
      line_in = line_ff;
      col_in  = col_ff;
      len_in  = len_ff;
      kbuf_in = kbuf_ff;
      if (take) begin
         if (eos) begin
            mode_in = MODE_IDLE;
            pend_in = PEND_ASSIGN;
            line_in = LINE_BITS'(1);
            col_in  = COLUMN_BITS'(1);
            len_in  = '0;
            kbuf_in = '0;
         end else if (op_pair) begin
            col_in  = col_inc;
            mode_in = MODE_IDLE;
         end else if (num_more) begin
            col_in = col_inc;
            len_in = len_inc;
            if (b == ".") begin
               mode_in = MODE_FRAC;
            end
         end else if (ident_more) begin
            for (int i = 0; i < KEYWORD_MAX; i++) begin
               if (len_ff == LENGTH_BITS'(i)) begin
                  kbuf_in[8*i +: 8] = b;
               end
            end
            col_in = col_inc;
            len_in = len_inc;
         end else if (in_str) begin
            col_in = col_inc;
            if (b == "\"") begin
               mode_in = MODE_IDLE;
            end else begin
               len_in = len_inc;
            end
         end else begin
            mode_in = MODE_IDLE;
            col_in  = col_inc;
            if (is_space(b)) begin
               if (b == CH_NEWLINE) begin
                  line_in = line_inc;
                  col_in  = COLUMN_BITS'(1);
               end
            end else begin
               case (b)
                  "=": begin
                     mode_in = MODE_OP;
                     pend_in = PEND_ASSIGN;
                  end
                  "<": begin
                     mode_in = MODE_OP;
                     pend_in = PEND_LESS;
                  end
                  ">": begin
                     mode_in = MODE_OP;
                     pend_in = PEND_GREATER;
                  end
                  "!": begin
                     mode_in = MODE_OP;
                     pend_in = PEND_NOT;
                  end
                  "\"": begin
                     mode_in = MODE_STR;
                     len_in  = '0;
                  end
                  default: begin
                     if (is_digit(b)) begin
                        mode_in = MODE_INT;
                        len_in  = LENGTH_BITS'(1);
                     end else if (is_alpha(b) || (b == "_")) begin
                        mode_in = MODE_IDENT;
                        len_in  = LENGTH_BITS'(1);
                        kbuf_in = KB_BITS'(b);
                     end
                  end
               endcase
            end
         end
      end
   end

   // tokens produced by this transfer
   always_comb begin
      tok_type fl;
      tok_type sc;
      fl      = make_tok(fl_kind, line_ff, col_ff, fl_len, 1'b0);
      fl.decl = (fl_kind == K_IDENTIFIER) && prev_ff;
      sc      = make_tok(char_kind(b), line_ff, col_inc, LENGTH_BITS'(1), 1'b0);
      n_tok   = 2'd0;
      tok0    = fl;
      tok1    = sc;
      prev_in = prev_ff;
      if (take) begin
         if (eos) begin
            if (do_flush) begin
               tok1  = make_tok(K_END_OF_FILE, line_ff, col_ff, '0, 1'b1);
               n_tok = 2'd2;
            end else begin
               tok0  = make_tok(K_END_OF_FILE, line_ff, col_ff, '0, 1'b1);
               n_tok = 2'd1;
            end
         end else if (op_pair) begin
            tok0  = make_tok(op_double(pend_ff), line_ff, col_inc, LENGTH_BITS'(2), 1'b0);
            n_tok = 2'd1;
         end else if (in_str && (b == "\"")) begin
            tok0  = make_tok(K_STRING_LITERAL, line_ff, col_inc, len_ff, 1'b0);
            n_tok = 2'd1;
         end else if (scanning) begin
            if (do_flush) begin
               n_tok = scan_hit ? 2'd2 : 2'd1;
            end else if (scan_hit) begin
               tok0  = sc;
               n_tok = 2'd1;
            end
         end
         if (eos) begin
            prev_in = 1'b0;
         end else if (n_tok == 2'd2) begin
            prev_in = is_type_kind(tok1.kind);
         end else if (n_tok == 2'd1) begin
            prev_in = is_type_kind(tok0.kind);
         end
      end
   end

   // token queue, head in slot 0
   always_comb begin
      base = cnt_ff - {1'b0, pop};
      for (int i = 0; i < QDEPTH; i++) begin
         q_in[i] = q_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < QDEPTH - 1; i++) begin
            q_in[i] = q_ff[i+1];
         end
      end
      for (int i = 0; i < QDEPTH; i++) begin
         if ((n_tok != 2'd0) && ({1'b0, base} == 3'(i))) begin
            q_in[i] = tok0;
         end
         if ((n_tok == 2'd2) && ({1'b0, base} + 3'd1 == 3'(i))) begin
            q_in[i] = tok1;
         end
      end
      cnt_in = base + n_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pend_ff <= PEND_ASSIGN;
         line_ff <= LINE_BITS'(1);
         col_ff  <= COLUMN_BITS'(1);
         len_ff  <= '0;
         kbuf_ff <= '0;
         prev_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         line_ff <= line_in;
         col_ff  <= col_in;
         len_ff  <= len_in;
         kbuf_ff <= kbuf_in;
         prev_ff <= prev_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = DATA_BITS'({q_ff[0].length, q_ff[0].column, q_ff[0].line});
   assign rsp_tuser  = {q_ff[0].decl, q_ff[0].kind};
   assign rsp_tlast  = q_ff[0].last;

`include "c_like_token_lexer_assert.svh"

   `CTLEX_ASSERT_NEXT(a_eos_resets, clock, reset, take && eos, (mode_ff == MODE_IDLE) && (line_ff == LINE_BITS'(1)) && !prev_ff)
   `CTLEX_ASSERT_NOW(a_last_is_eof, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser[5:0] == K_END_OF_FILE)
   `CTLEX_ASSERT_NOW(a_decl_on_ident, clock, reset, rsp_tvalid && rsp_tuser[6], rsp_tuser[5:0] == K_IDENTIFIER)

endmodule

### verif/tb_c_like_token_lexer.sv
// self-checking testbench for c_like_token_lexer: a directed table, then random source text
// under four stall mixes, every token compared with the table or an in-bench lexer model
// depends on rtl/ctlex_pkg.sv and rtl/c_like_token_lexer.sv
module tb_c_like_token_lexer;
   timeunit 1ns;
   timeprecision 1ps;
   import ctlex_pkg::*;

   localparam int DATA_W      = ((LINE_BITS_DEF + COLUMN_BITS_DEF + LENGTH_BITS_DEF + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_BYTES = 175;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] line;
      logic [11:0] column;
      logic [11:0] length;
      logic        decl;
      logic        fin;
   } exp_tok_type;

   typedef struct {
      logic [7:0]  b;
      logic        eof;
      bit          typed;
      exp_tok_type tok;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [7:0]        req_tdata;   // source_byte
   logic              req_tlast;   // end_of_source
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;   // token_line, token_column, value_length
   logic [6:0]        rsp_tuser;   // token_kind, declares_symbol
   logic              rsp_tlast;   // final_token

   c_like_token_lexer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   string kw_names [11] = '{"if", "else", "while", "for", "return", "int",
                            "float", "double", "char", "string", "void"};
   byte   blanks [6]    = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
   string op_chars      = "+-*/%(){};,=<>!&|";

   // lexer model state
   mode_type    lx_mode;
   pend_type    lx_pend;
   logic [15:0] lx_line;
   logic [11:0] lx_col;
   logic [11:0] lx_len;
   logic [47:0] lx_word;
   logic        lx_after_type;

   exp_tok_type  fresh_tokens[$];
   exp_tok_type  expected_tokens[$];
   stim_row_type directed_rows[$];
   exp_tok_type  want_tok;

   int send_idle_pct;
   int recv_stall_pct;
   int mismatches;
   int bytes_sent;
   int tokens_checked;
   int cycle_count;

   always #5 clock = ~clock;

   function automatic logic digit_b(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic letter_b(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic [11:0] inc12(logic [11:0] v);
      return (v == '1) ? v : v + 12'd1;
   endfunction

   function automatic kind_type op_alone(pend_type p);
      case (p)
         PEND_ASSIGN:  return K_ASSIGN;
         PEND_LESS:    return K_LESS_THAN;
         PEND_GREATER: return K_GREATER_THAN;
         default:      return K_LOGICAL_NOT;
      endcase
   endfunction

   function automatic kind_type op_with_eq(pend_type p);
      case (p)
         PEND_ASSIGN:  return K_EQUAL;
         PEND_LESS:    return K_LESS_EQUAL;
         PEND_GREATER: return K_GREATER_EQUAL;
         default:      return K_NOT_EQUAL;
      endcase
   endfunction

   function automatic void clear_lexer();
      lx_mode       = MODE_IDLE;
      lx_pend       = PEND_ASSIGN;
      lx_line       = 16'd1;
      lx_col        = 12'd1;
      lx_len        = '0;
      lx_word       = '0;
      lx_after_type = 1'b0;
   endfunction

   function automatic void push_token(kind_type k, logic [11:0] n);
      exp_tok_type t;
      t.kind   = k;
      t.line   = lx_line;
      t.column = lx_col;
      t.length = n;
      t.decl   = (k == K_IDENTIFIER) && lx_after_type;
      t.fin    = (k == K_END_OF_FILE);
      lx_after_type = (k >= K_INT) && (k <= K_VOID);
      fresh_tokens.insert(fresh_tokens.size(), t);
   endfunction

   function automatic kind_type word_kind();
      bit hit;
      for (int k = 0; k < 11; k++) begin
         hit = (kw_names[k].len() == lx_len);
         for (int i = 0; i < kw_names[k].len() && hit; i++)
            hit = (kw_names[k][i] == lx_word[8*i +: 8]);
         if (hit)
            return kind_type'(K_IF + k);
      end
      return K_IDENTIFIER;
   endfunction

   function automatic void flush_pending();
      case (lx_mode)
         MODE_OP:    push_token(op_alone(lx_pend), 12'd1);
         MODE_INT:   push_token(K_INTEGER_LITERAL, lx_len);
         MODE_FRAC:  push_token(K_FLOAT_LITERAL, lx_len);
         MODE_IDENT: push_token(word_kind(), lx_len);
         MODE_STR:   push_token(K_STRING_LITERAL, lx_len);
         default:    ;
      endcase
      lx_mode = MODE_IDLE;
   endfunction

   function automatic void lex_byte(logic [7:0] b, logic eof);
      if (eof) begin
         flush_pending();
         push_token(K_END_OF_FILE, '0);
         clear_lexer();
         return;
      end
      case (lx_mode)
         MODE_OP: begin
            if (b == "=") begin
               lx_col = inc12(lx_col);
               push_token(op_with_eq(lx_pend), 12'd2);
               lx_mode = MODE_IDLE;
               return;
            end
            flush_pending();
         end
         MODE_INT, MODE_FRAC: begin
            if (digit_b(b) || (b == "." && lx_mode == MODE_INT)) begin
               lx_col = inc12(lx_col);
               lx_len = inc12(lx_len);
               if (b == ".")
                  lx_mode = MODE_FRAC;
               return;
            end
            flush_pending();
         end
         MODE_IDENT: begin
            if (letter_b(b) || digit_b(b) || b == "_") begin
               if (lx_len < KEYWORD_MAX_DEF)
                  lx_word[8*lx_len +: 8] = b;
               lx_col = inc12(lx_col);
               lx_len = inc12(lx_len);
               return;
            end
            flush_pending();
         end
         MODE_STR: begin
            lx_col = inc12(lx_col);
            if (b == "\"") begin
               push_token(K_STRING_LITERAL, lx_len);
               lx_mode = MODE_IDLE;
            end else begin
               lx_len = inc12(lx_len);
            end
            return;
         end
         default: lx_mode = MODE_IDLE;
      endcase

      // start of a new token
      lx_col = inc12(lx_col);
      if (b == " " || (b >= 8'h09 && b <= 8'h0D)) begin
         if (b == 8'h0A) begin
            if (lx_line != '1)
               lx_line = lx_line + 16'd1;
            lx_col = 12'd1;
         end
         return;
      end
      case (b)
         "+":  push_token(K_PLUS, 12'd1);
         "-":  push_token(K_MINUS, 12'd1);
         "*":  push_token(K_MULTIPLY, 12'd1);
         "/":  push_token(K_DIVIDE, 12'd1);
         "%":  push_token(K_MODULO, 12'd1);
         "(":  push_token(K_LEFT_PAREN, 12'd1);
         ")":  push_token(K_RIGHT_PAREN, 12'd1);
         "{":  push_token(K_LEFT_BRACE, 12'd1);
         "}":  push_token(K_RIGHT_BRACE, 12'd1);
         ";":  push_token(K_SEMICOLON, 12'd1);
         ",":  push_token(K_COMMA, 12'd1);
         "=":  begin lx_mode = MODE_OP; lx_pend = PEND_ASSIGN; end
         "<":  begin lx_mode = MODE_OP; lx_pend = PEND_LESS; end
         ">":  begin lx_mode = MODE_OP; lx_pend = PEND_GREATER; end
         "!":  begin lx_mode = MODE_OP; lx_pend = PEND_NOT; end
         "\"": begin lx_mode = MODE_STR; lx_len = '0; end
         default: begin
            if (digit_b(b)) begin
               lx_mode = MODE_INT;
               lx_len  = 12'd1;
            end else if (letter_b(b) || b == "_") begin
               lx_mode = MODE_IDENT;
               lx_len  = 12'd1;
               lx_word = {40'd0, b};
            end else begin
               push_token(K_UNKNOWN, 12'd1);
            end
         end
      endcase
   endfunction

   function automatic void add_row(logic [7:0] b, logic eof, bit typed, exp_tok_type t);
      stim_row_type r;
      r.b     = b;
      r.eof   = eof;
      r.typed = typed;
      r.tok   = t;
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++)
         add_row(s[i], 1'b0, 1'b0, '0);
   endfunction

   function automatic logic [7:0] pick_letter();
      int r;
      r = $urandom_range(0, 51);
      return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // one byte transfer; typed rows replace the model's tokens with the table's
   task automatic accept(input logic [7:0] b, input logic eof = 1'b0,
                         input bit typed = 1'b0, input exp_tok_type tok = '0);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eof;
      do @(posedge clock); while (!req_tready);
      lex_byte(b, eof);
      if (typed) begin
         fresh_tokens.delete();
         fresh_tokens.insert(0, tok);
      end
      while (fresh_tokens.size() != 0)
         expected_tokens.insert(expected_tokens.size(), fresh_tokens.pop_front());
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_word();
      int n;
      int r;
      n = $urandom_range(1, 9);
      accept(($urandom_range(0, 4) == 0) ? 8'("_") : pick_letter());
      repeat (n - 1) begin
         r = $urandom_range(0, 9);
         if (r < 6)
            accept(pick_letter());
         else if (r < 9)
            accept(8'("0" + $urandom_range(0, 9)));
         else
            accept("_");
      end
   endtask

   task automatic send_lexeme();
      int          r;
      string       w;
      logic [7:0]  c;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         w = kw_names[$urandom_range(0, 10)];
         for (int i = 0; i < w.len(); i++)
            accept(w[i]);
         if ($urandom_range(0, 1)) begin
            accept(" ");
            send_word();
         end
      end else if (r < 30) begin
         send_word();
      end else if (r < 42) begin
         repeat ($urandom_range(1, 4))
            accept(8'("0" + $urandom_range(0, 9)));
         if ($urandom_range(0, 2) == 0) begin
            accept(".");
            repeat ($urandom_range(0, 3))
               accept(8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 5) == 0)
               accept(".");
         end
      end else if (r < 52) begin
         accept("\"");
         repeat ($urandom_range(0, 6)) begin
            c = 8'($urandom_range(32, 126));
            if (c == "\"")
               c = "x";
            if ($urandom_range(0, 9) == 0)
               c = 8'h0A;
            accept(c);
         end
         if ($urandom_range(0, 99) < 85)
            accept("\"");
      end else if (r < 70) begin
         accept(op_chars[$urandom_range(0, op_chars.len() - 1)]);
         if ($urandom_range(0, 9) < 3)
            accept("=");
      end else if (r < 85) begin
         accept(blanks[$urandom_range(0, 5)]);
      end else if (r < 98) begin
         accept(8'($urandom_range(0, 255)));
      end else begin
         accept(8'($urandom), 1'b1);
      end
      if ($urandom_range(0, 1))
         accept(" ");
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tokens.size() == 0) begin
            $error("token with no expectation: kind %0d line %0d column %0d",
                   rsp_tuser[5:0], rsp_tdata[15:0], rsp_tdata[27:16]);
            mismatches++;
         end else begin
            want_tok = expected_tokens.pop_front();
            check_field("token_kind", want_tok.kind, rsp_tuser[5:0]);
            check_field("token_line", want_tok.line, rsp_tdata[15:0]);
            check_field("token_column", want_tok.column, rsp_tdata[27:16]);
            check_field("value_length", want_tok.length, rsp_tdata[39:28]);
            check_field("declares_symbol", want_tok.decl, rsp_tuser[6]);
            check_field("final_token", want_tok.fin, rsp_tlast);
            tokens_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d tokens outstanding",
                  cycle_count, expected_tokens.size());
         $display("tb_c_like_token_lexer failed");
         $finish;
      end
   end

   initial begin
      int idle_mix [4];
      int stall_mix [4];
      int mark;
      idle_mix       = '{0, 62, 0, 17};
      stall_mix      = '{0, 0, 62, 17};
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      mismatches     = 0;
      bytes_sent     = 0;
      tokens_checked = 0;
      cycle_count    = 0;
      clear_lexer();

      // end of source right after reset, single-byte extremes, ampersand and bar
      add_row(8'h00, 1'b1, 1'b1, '{K_END_OF_FILE, 16'd1, 12'd1, 12'd0, 1'b0, 1'b1});
      add_row("+",   1'b0, 1'b1, '{K_PLUS,        16'd1, 12'd2, 12'd1, 1'b0, 1'b0});
      add_row(8'hFF, 1'b0, 1'b1, '{K_UNKNOWN,     16'd1, 12'd3, 12'd1, 1'b0, 1'b0});
      add_row("&",   1'b0, 1'b1, '{K_UNKNOWN,     16'd1, 12'd4, 12'd1, 1'b0, 1'b0});
      add_row("|",   1'b0, 1'b1, '{K_UNKNOWN,     16'd1, 12'd5, 12'd1, 1'b0, 1'b0});
      add_row(8'h00, 1'b0, 1'b1, '{K_UNKNOWN,     16'd1, 12'd6, 12'd1, 1'b0, 1'b0});
      // declaration, float, two tokens from one byte, compound operators,
      // newline inside a string, unterminated string at end of source
      add_text("\nint x=3.5;<=>!=\"\n\"\"q");
      add_row(8'h5A, 1'b1, 1'b0, '0);

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_mix[p];
         recv_stall_pct = stall_mix[p];
         if (p == 0) begin
            foreach (directed_rows[i])
               accept(directed_rows[i].b, directed_rows[i].eof,
                      directed_rows[i].typed, directed_rows[i].tok);
            drain();
         end
         mark = bytes_sent;
         while (bytes_sent - mark < PHASE_BYTES)
            send_lexeme();
         accept(8'($urandom), 1'b1);
         drain();
      end

      repeat (20) @(posedge clock);
      $display("%0d source bytes sent, %0d tokens checked, %0d mismatches",
               bytes_sent, tokens_checked, mismatches);
      $display("directed table and random text hit every token class, noise bytes and");
      $display("end-of-source flushes, with sender gaps and receiver stalls in four mixes");
      if (mismatches == 0 && expected_tokens.size() == 0)
         $display("tb_c_like_token_lexer passed");
      else
         $display("tb_c_like_token_lexer failed");
      $finish;
   end

endmodule
